// ===== design/mcg_pkg.sv =====
// Shared types, codes and constants for the motor current guard.
`default_nettype none

package mcg_pkg;

  localparam int AVG_TAPS_DEF = 5;

  localparam int ADC_W      = 12;
  localparam int MA_W       = 12;
  localparam int THR_W      = 13;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 8;
  localparam int PHASE_W    = 3;
  localparam int EVENT_W    = 3;
  localparam int LEVEL_W    = 3;
  localparam int DUTY_W     = 10;
  localparam int CNT_W      = 3;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Converter scaling: mA = floor(code * ADC_SCALE / 2^16) - ADC_OFFSET, floored at 0
  localparam int ADC_SCALE_W = 16;
  localparam logic [ADC_SCALE_W-1:0] ADC_SCALE  = 16'd44810;
  localparam logic [MA_W-1:0]        ADC_OFFSET = 12'd62;

  localparam logic [PHASE_W-1:0] PH_OFF   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CALIB = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RUN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OPEN  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STALL = 3'd5;

  localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CALIB = 3'd1;
  localparam logic [EVENT_W-1:0] EV_END   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_OPEN  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_STALL = 3'd4;

  // Classified request operations
  localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_FWD    = 3'd1;
  localparam logic [OP_W-1:0] OP_REV    = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_UP     = 3'd4;
  localparam logic [OP_W-1:0] OP_DOWN   = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd6;

  localparam logic [CMD_W-1:0] CMD_FWD  = 8'h44;
  localparam logic [CMD_W-1:0] CMD_REV  = 8'h41;
  localparam logic [CMD_W-1:0] CMD_STOP = 8'h53;
  localparam logic [CMD_W-1:0] CMD_UP   = 8'h2B;
  localparam logic [CMD_W-1:0] CMD_DOWN = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CALIB   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_THR    = 3'd7;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 3'd7;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] time_ms;
    logic [ADC_W-1:0]  adc_code;
    logic [CMD_W-1:0]  command_byte;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] motor_phase;
    logic               drive_forward;
    logic               drive_reverse;
    logic [DUTY_W-1:0]  duty_compare;
    logic [LEVEL_W-1:0] speed_step;
    logic [MA_W-1:0]    mean_current_ma;
    logic [THR_W-1:0]   trip_level_ma;
    logic [CNT_W-1:0]   over_count;
    logic [EVENT_W-1:0] event_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0]      start_delay_ms;
    logic [15:0]      calib_end_ms;
    logic [15:0]      run_limit_ms;
    logic [15:0]      open_timeout_ms;
    logic [CNT_W-1:0] stall_count_limit;
    logic [MA_W-1:0]  open_level_ma;
    logic [MA_W-1:0]  min_calib_ma;
    logic [MA_W-1:0]  idle_threshold_ma;
  } cfg_t;

  // Request handed from the front to the back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] time_ms;
    logic [MA_W-1:0]   mean_ma;
  } req_t;

  function automatic logic [DUTY_W-1:0] speed_duty(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    case (lvl)
      3'd1:    d = 10'd700;
      3'd2:    d = 10'd800;
      3'd3:    d = 10'd900;
      3'd4:    d = 10'd999;
      default: d = 10'd700;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/mcg_front.sv =====
// Front pipeline: converts samples, decodes commands, keeps the sample mean.
`default_nettype none

module mcg_front #(
  parameter int AVG_TAPS = mcg_pkg::AVG_TAPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mcg_pkg::in_item_t in_data,
  output logic                  req_valid,
  input  wire logic             req_ready,
  output mcg_pkg::req_t         req_data
);
  import mcg_pkg::*;

  localparam int TAP_W   = $clog2(AVG_TAPS);
  localparam int SUM_W   = MA_W + TAP_W;
  localparam int MUL_W   = SUM_W + 1;
  localparam int MEAN_SH = SUM_W + TAP_W;
  localparam int PROD_W  = SUM_W + MUL_W;
  // Round-up reciprocal: exact floor quotient for every SUM_W-bit sum
  localparam longint MEAN_MUL_L = ((64'd1 <<< MEAN_SH) + AVG_TAPS - 1) / AVG_TAPS;
  localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(MEAN_MUL_L);

  logic advance;

  // Stage 1: classified item and converted current
  logic              s1_v_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [TIME_W-1:0] s1_time_r;
  logic [MA_W-1:0]   s1_ma_r;

  // Stage 2: history update
  logic              s2_v_r;
  logic [OP_W-1:0]   s2_op_r;
  logic [TIME_W-1:0] s2_time_r;

  // Stage 3: mean
  logic              s3_v_r;
  req_t              s3_req_r;

  logic [MA_W-1:0]   hist_r [AVG_TAPS];
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;

  logic [ADC_W+ADC_SCALE_W-1:0] adc_prod;
  logic [MA_W-1:0]   adc_scaled;
  logic [MA_W-1:0]   ma_nxt;
  logic [OP_W-1:0]   op_nxt;
  logic [PROD_W-1:0] mean_prod;
  logic [MA_W-1:0]   mean_nxt;

  assign advance  = req_ready || !s3_v_r;
  assign in_stall = !advance;

  assign adc_prod   = (ADC_W+ADC_SCALE_W)'(in_data.adc_code) *
                      (ADC_W+ADC_SCALE_W)'(ADC_SCALE);
  assign adc_scaled = adc_prod[ADC_SCALE_W +: MA_W];
  assign ma_nxt     = (adc_scaled > ADC_OFFSET) ? adc_scaled - ADC_OFFSET : '0;

  always_comb begin
    if (!in_data.mode) begin
      op_nxt = OP_SAMPLE;
    end else begin
      unique case (in_data.command_byte)
        CMD_FWD:  op_nxt = OP_FWD;
        CMD_REV:  op_nxt = OP_REV;
        CMD_STOP: op_nxt = OP_STOP;
        CMD_UP:   op_nxt = OP_UP;
        CMD_DOWN: op_nxt = OP_DOWN;
        default:  op_nxt = OP_NONE;
      endcase
    end
  end

  assign sum_nxt = sum_r - SUM_W'(hist_r[0]) + SUM_W'(s1_ma_r);

  // sum_r only moves on advance, so it always matches the item held in stage 2
  assign mean_prod = PROD_W'(sum_r) * PROD_W'(MEAN_MUL);
  assign mean_nxt  = mean_prod[MEAN_SH +: MA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sum_r  <= '0;
      for (int i = 0; i < AVG_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (advance) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s1_v_r && s1_op_r == OP_SAMPLE) begin
        for (int i = 0; i < AVG_TAPS - 1; i++) begin
          hist_r[i] <= hist_r[i+1];
        end
        hist_r[AVG_TAPS-1] <= s1_ma_r;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r   <= op_nxt;
      s1_time_r <= in_data.time_ms;
      s1_ma_r   <= ma_nxt;
      s2_op_r   <= s1_op_r;
      s2_time_r <= s1_time_r;
      s3_req_r  <= '{op: s2_op_r, time_ms: s2_time_r, mean_ma: mean_nxt};
    end
  end

  assign req_valid = s3_v_r;
  assign req_data  = s3_req_r;

endmodule

`default_nettype wire

// ===== design/mcg_queue.sv =====
// Two-entry request queue between front and back.
`default_nettype none

module mcg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire mcg_pkg::req_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output mcg_pkg::req_t      pop_data
);
  import mcg_pkg::*;

  req_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/mcg_back.sv =====
// Back end: guard state machine, speed level and the result register.
`default_nettype none

module mcg_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mcg_pkg::cfg_t     cfg,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire mcg_pkg::req_t     req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mcg_pkg::out_item_t     out_data
);
  import mcg_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TIME_W-1:0]  start_stamp_r, start_stamp_nxt;
  logic [TIME_W-1:0]  susp_stamp_r, susp_stamp_nxt;
  logic               susp_valid_r, susp_valid_nxt;
  logic [CNT_W-1:0]   over_cnt_r, over_cnt_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               rev_r, rev_nxt;
  logic [EVENT_W-1:0] event_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               pop;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  susp_gap;
  logic [MA_W-1:0]    base;
  logic [CNT_W-1:0]   over_inc;
  logic               driving;

  assign req_ready = !out_valid_r || !out_stall;
  assign pop       = req_valid && req_ready;

  assign elapsed  = req.time_ms - start_stamp_r;
  assign susp_gap = req.time_ms - susp_stamp_r;
  assign base     = (req.mean_ma < cfg.min_calib_ma) ? cfg.min_calib_ma : req.mean_ma;
  assign over_inc = (over_cnt_r < CNT_MAX) ? over_cnt_r + 1'b1 : over_cnt_r;

  always_comb begin
    phase_nxt       = phase_r;
    start_stamp_nxt = start_stamp_r;
    susp_stamp_nxt  = susp_stamp_r;
    susp_valid_nxt  = susp_valid_r;
    over_cnt_nxt    = over_cnt_r;
    thr_nxt         = thr_r;
    level_nxt       = level_r;
    rev_nxt         = rev_r;
    event_nxt       = EV_NONE;
    if (pop) begin
      unique case (req.op) inside
        OP_SAMPLE: begin
          unique case (phase_r)
            PH_START: begin
              if (elapsed > TIME_W'(cfg.start_delay_ms)) begin
                phase_nxt = PH_CALIB;
              end
            end
            PH_CALIB: begin
              if (elapsed > TIME_W'(cfg.calib_end_ms)) begin
                // threshold = floor(1.25 * base)
                thr_nxt   = THR_W'(base) + THR_W'(base >> 2);
                phase_nxt = PH_RUN;
                event_nxt = EV_CALIB;
              end
            end
            PH_RUN: begin
              if (elapsed > TIME_W'(cfg.run_limit_ms)) begin
                phase_nxt = PH_OFF;
                thr_nxt   = THR_W'(cfg.idle_threshold_ma);
                event_nxt = EV_END;
              end else if (req.mean_ma < cfg.open_level_ma) begin
                if (!susp_valid_r) begin
                  susp_valid_nxt = 1'b1;
                  susp_stamp_nxt = req.time_ms;
                end else if (susp_gap >= TIME_W'(cfg.open_timeout_ms)) begin
                  phase_nxt      = PH_OPEN;
                  susp_valid_nxt = 1'b0;
                  event_nxt      = EV_OPEN;
                end
              end else begin
                susp_valid_nxt = 1'b0;
                if (THR_W'(req.mean_ma) > thr_r) begin
                  over_cnt_nxt = over_inc;
                  if (over_inc >= cfg.stall_count_limit) begin
                    phase_nxt = PH_STALL;
                    event_nxt = EV_STALL;
                  end
                end else begin
                  over_cnt_nxt = '0;
                end
              end
            end
            default: begin
              // off and latched faults: history only
            end
          endcase
        end
        OP_FWD, OP_REV: begin
          rev_nxt         = (req.op == OP_REV);
          start_stamp_nxt = req.time_ms;
          phase_nxt       = PH_START;
          over_cnt_nxt    = '0;
        end
        OP_STOP: begin
          phase_nxt = PH_OFF;
          thr_nxt   = THR_W'(cfg.idle_threshold_ma);
        end
        OP_UP: begin
          if (level_r < LEVEL_MAX) begin
            level_nxt = level_r + 1'b1;
          end
        end
        OP_DOWN: begin
          if (level_r > LEVEL_MIN) begin
            level_nxt = level_r - 1'b1;
          end
        end
        default: begin
          // unknown command byte: no state change
        end
      endcase
    end
  end

  assign driving = (phase_nxt == PH_START) || (phase_nxt == PH_CALIB) ||
                   (phase_nxt == PH_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OFF;
      start_stamp_r <= '0;
      susp_stamp_r  <= '0;
      susp_valid_r  <= 1'b0;
      over_cnt_r    <= '0;
      thr_r         <= 13'd1000;
      level_r       <= LEVEL_MIN;
      rev_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      start_stamp_r <= start_stamp_nxt;
      susp_stamp_r  <= susp_stamp_nxt;
      susp_valid_r  <= susp_valid_nxt;
      over_cnt_r    <= over_cnt_nxt;
      thr_r         <= thr_nxt;
      level_r       <= level_nxt;
      rev_r         <= rev_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= '{
        motor_phase:     phase_nxt,
        drive_forward:   driving && !rev_nxt,
        drive_reverse:   driving && rev_nxt,
        duty_compare:    speed_duty(level_nxt),
        speed_step:      level_nxt,
        mean_current_ma: req.mean_ma,
        trip_level_ma:   thr_nxt,
        over_count:      over_cnt_nxt,
        event_code:      event_nxt
      };
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/motor_current_guard_fsm.sv =====
// Top level of the motor current guard: configuration registers and the three parts.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------
//   in_       | in_valid/in_stall  | in_data (mode, time, adc, cmd)
//   out_      | out_valid/out_stall| out_data (phase, drive, mean..)
//   cfg_      | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall stays low; a request reaches out_data
// through three front stages (converter multiply, history update, reciprocal multiply
// for the mean), an entry of the two-entry queue and the result register.
// Synchronous active-low reset restores every state and valid register; no clearing pass.
// in_stall rises only while the queue is full and the last front stage holds a request;
// out_stall holds the result register and fills the queue behind it.
`default_nettype none

module motor_current_guard_fsm #(
  parameter int AVG_TAPS = mcg_pkg::AVG_TAPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mcg_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mcg_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [mcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mcg_pkg::*;

  cfg_t cfg_r;
  logic q_push_valid, q_push_ready;
  req_t q_push_data;
  logic q_pop_valid, q_pop_ready;
  req_t q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay_ms    <= 16'd2000;
      cfg_r.calib_end_ms      <= 16'd3000;
      cfg_r.run_limit_ms      <= 16'd20000;
      cfg_r.open_timeout_ms   <= 16'd5000;
      cfg_r.stall_count_limit <= 3'd5;
      cfg_r.open_level_ma     <= 12'd40;
      cfg_r.min_calib_ma      <= 12'd50;
      cfg_r.idle_threshold_ma <= 12'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_DELAY: cfg_r.start_delay_ms    <= cfg_wdata;
        REG_CALIB_END:   cfg_r.calib_end_ms      <= cfg_wdata;
        REG_RUN_LIMIT:   cfg_r.run_limit_ms      <= cfg_wdata;
        REG_OPEN_TMO:    cfg_r.open_timeout_ms   <= cfg_wdata;
        REG_STALL_LIMIT: cfg_r.stall_count_limit <= cfg_wdata[CNT_W-1:0];
        REG_OPEN_LEVEL:  cfg_r.open_level_ma     <= cfg_wdata[MA_W-1:0];
        REG_MIN_CALIB:   cfg_r.min_calib_ma      <= cfg_wdata[MA_W-1:0];
        REG_IDLE_THR:    cfg_r.idle_threshold_ma <= cfg_wdata[MA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcg_front #(
    .AVG_TAPS (AVG_TAPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .req_valid (q_push_valid),
    .req_ready (q_push_ready),
    .req_data  (q_push_data)
  );

  mcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  mcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (q_pop_valid),
    .req_ready (q_pop_ready),
    .req       (q_pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_code == EV_STALL) |-> out_data.motor_phase == PH_STALL)
    else $error("stall event without stall phase");

  a_calib_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_code == EV_CALIB) |-> out_data.motor_phase == PH_RUN)
    else $error("calibration event without run phase");

  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.drive_forward && out_data.drive_reverse))
    else $error("both drive channels enabled");

  a_duty_matches_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.duty_compare == speed_duty(out_data.speed_step))
    else $error("duty compare does not match speed step");

endmodule

`default_nettype wire

// ===== verif/motor_current_guard_fsm_tb.sv =====
// Self-checking testbench for the motor current guard: directed table, then random runs.
`timescale 1ns / 100ps

module motor_current_guard_fsm_tb;
  import mcg_pkg::*;

  localparam int TAPS = AVG_TAPS_DEF;
  localparam logic [3:0][DUTY_W-1:0] DUTY_STEPS = {10'd999, 10'd900, 10'd800, 10'd700};

  typedef struct packed {
    in_item_t  req;
    logic      fixed_want;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_current_guard_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard state as the predictor sees it
  cfg_t              g_cfg;
  logic [MA_W-1:0]   hist_ma [TAPS];
  logic [PHASE_W-1:0] g_phase;
  logic [TIME_W-1:0] g_start;
  logic [TIME_W-1:0] g_suspect;
  logic              g_suspect_ok;
  logic [CNT_W-1:0]  g_over;
  logic [THR_W-1:0]  g_trip;
  logic [MA_W-1:0]   g_calib;
  logic [LEVEL_W-1:0] g_level;
  logic [DUTY_W-1:0] g_duty;
  logic              g_rev;

  out_item_t pending_status [$];
  dir_row_t  dir_rows [$];
  logic [CFG_DATA_W-1:0] reg_plan [8];
  logic [TIME_W-1:0] clock_ms;
  int  accepted_count = 0;
  int  status_mismatches = 0;
  bit  quiet = 1'b0;

  task automatic guard_reset();
    g_cfg.start_delay_ms    = 16'd2000;
    g_cfg.calib_end_ms      = 16'd3000;
    g_cfg.run_limit_ms      = 16'd20000;
    g_cfg.open_timeout_ms   = 16'd5000;
    g_cfg.stall_count_limit = 3'd5;
    g_cfg.open_level_ma     = 12'd40;
    g_cfg.min_calib_ma      = 12'd50;
    g_cfg.idle_threshold_ma = 12'd1000;
    for (int i = 0; i < TAPS; i++) hist_ma[i] = '0;
    g_phase      = PH_OFF;
    g_start      = '0;
    g_suspect    = '0;
    g_suspect_ok = 1'b0;
    g_over       = '0;
    g_trip       = 13'd1000;
    g_calib      = '0;
    g_level      = LEVEL_MIN;
    g_duty       = 10'd700;
    g_rev        = 1'b0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    case (idx)
      REG_START_DELAY: g_cfg.start_delay_ms    = v;
      REG_CALIB_END:   g_cfg.calib_end_ms      = v;
      REG_RUN_LIMIT:   g_cfg.run_limit_ms      = v;
      REG_OPEN_TMO:    g_cfg.open_timeout_ms   = v;
      REG_STALL_LIMIT: g_cfg.stall_count_limit = v[CNT_W-1:0];
      REG_OPEN_LEVEL:  g_cfg.open_level_ma     = v[MA_W-1:0];
      REG_MIN_CALIB:   g_cfg.min_calib_ma      = v[MA_W-1:0];
      REG_IDLE_THR:    g_cfg.idle_threshold_ma = v[MA_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [MA_W-1:0] code_to_ma(input logic [ADC_W-1:0] code);
    logic [27:0] prod;
    logic [11:0] scaled;
    prod   = {16'b0, code} * {12'b0, ADC_SCALE};
    scaled = prod[27:16];
    return (scaled > ADC_OFFSET) ? scaled - ADC_OFFSET : '0;
  endfunction

  function automatic logic [MA_W-1:0] history_mean_ma();
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < TAPS; i++) sum += hist_ma[i];
    return MA_W'(sum / TAPS);
  endfunction

  task automatic predict_guard_status(input in_item_t r, output out_item_t s);
    logic [TIME_W-1:0] elapsed;
    int unsigned mean_ma;
    int unsigned base;
    logic [EVENT_W-1:0] ev;
    logic driving;
    ev = EV_NONE;
    if (r.mode == 1'b0) begin
      for (int i = 0; i < TAPS - 1; i++) hist_ma[i] = hist_ma[i + 1];
      hist_ma[TAPS - 1] = code_to_ma(r.adc_code);
      mean_ma = history_mean_ma();
      elapsed = r.time_ms - g_start;
      case (g_phase)
        PH_START: begin
          if (elapsed > g_cfg.start_delay_ms) g_phase = PH_CALIB;
        end
        PH_CALIB: begin
          if (elapsed > g_cfg.calib_end_ms) begin
            base    = (mean_ma < g_cfg.min_calib_ma) ? g_cfg.min_calib_ma : mean_ma;
            g_calib = MA_W'(base);
            g_trip  = THR_W'((base * 5) / 4);
            g_phase = PH_RUN;
            ev      = EV_CALIB;
          end
        end
        PH_RUN: begin
          if (elapsed > g_cfg.run_limit_ms) begin
            g_phase = PH_OFF;
            g_trip  = {1'b0, g_cfg.idle_threshold_ma};
            ev      = EV_END;
          end else if (mean_ma < g_cfg.open_level_ma) begin
            // first low sample only arms the open-load timer
            if (!g_suspect_ok) begin
              g_suspect_ok = 1'b1;
              g_suspect    = r.time_ms;
            end else if (TIME_W'(r.time_ms - g_suspect) >= g_cfg.open_timeout_ms) begin
              g_phase      = PH_OPEN;
              g_suspect_ok = 1'b0;
              ev           = EV_OPEN;
            end
          end else begin
            g_suspect_ok = 1'b0;
            if (mean_ma > g_trip) begin
              if (g_over != CNT_MAX) g_over = g_over + 3'd1;
              if (g_over >= g_cfg.stall_count_limit) begin
                g_phase = PH_STALL;
                ev      = EV_STALL;
              end
            end else begin
              g_over = '0;
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (r.command_byte)
        CMD_FWD, CMD_REV: begin
          g_rev   = (r.command_byte == CMD_REV);
          g_start = r.time_ms;
          g_phase = PH_START;
          g_over  = '0;
        end
        CMD_STOP: begin
          g_phase = PH_OFF;
          g_trip  = {1'b0, g_cfg.idle_threshold_ma};
        end
        CMD_UP: begin
          if (g_level < LEVEL_MAX) begin
            g_level = g_level + 3'd1;
            g_duty  = DUTY_STEPS[g_level - 3'd1];
          end
        end
        CMD_DOWN: begin
          if (g_level > LEVEL_MIN) begin
            g_level = g_level - 3'd1;
            g_duty  = DUTY_STEPS[g_level - 3'd1];
          end
        end
        default: ;
      endcase
    end
    driving = (g_phase == PH_START) || (g_phase == PH_CALIB) || (g_phase == PH_RUN);
    s.motor_phase     = g_phase;
    s.drive_forward   = driving && !g_rev;
    s.drive_reverse   = driving && g_rev;
    s.duty_compare    = g_duty;
    s.speed_step      = g_level;
    s.mean_current_ma = history_mean_ma();
    s.trip_level_ma   = g_trip;
    s.over_count      = g_over;
    s.event_code      = ev;
  endtask

  function automatic in_item_t make_req(input logic mode, input logic [TIME_W-1:0] t,
                                        input logic [ADC_W-1:0] adc,
                                        input logic [CMD_W-1:0] cmd);
    in_item_t r;
    r.mode         = mode;
    r.time_ms      = t;
    r.adc_code     = adc;
    r.command_byte = cmd;
    return r;
  endfunction

  task automatic add_row(input in_item_t req, input logic fixed_want, input out_item_t want);
    dir_row_t row;
    row.req        = req;
    row.fixed_want = fixed_want;
    row.want       = want;
    dir_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns status mismatch: %s got %0d want %0d", $time, what, got, want);
    status_mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Hold valid and payload until the request is taken
  task automatic send_request(input in_item_t req, input logic fixed_want,
                              input out_item_t want);
    out_item_t s;
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_guard_status(req, s);
    pending_status.push_back(fixed_want ? want : s);
    accepted_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= reg_plan[i];
      @(posedge clk);
      apply_register(CFG_IDX_W'(i), reg_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_command();
    case ($urandom_range(0, 5))
      0: return CMD_UP;
      1: return CMD_DOWN;
      2: return CMD_STOP;
      3: return CMD_FWD;
      4: return CMD_REV;
      default: return CMD_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic advance_clock(input int step_max);
    if ($urandom_range(0, 99) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
  endtask

  // One motor run: start, samples around a level that may jump once, maybe a stop; or a lone random request
  task automatic motor_run(input int step_max);
    int nsamp;
    int flip;
    int base;
    int adc;
    int r;
    if ($urandom_range(0, 99) < 10) begin
      send_request(make_req(1'($urandom_range(0, 1)), $urandom,
                            ADC_W'($urandom_range(0, 4095)),
                            CMD_W'($urandom_range(0, 255))), 1'b0, '0);
      return;
    end
    advance_clock(step_max);
    send_request(make_req(1'b1, clock_ms, ADC_W'($urandom_range(0, 4095)),
                          $urandom_range(0, 1) ? CMD_FWD : CMD_REV), 1'b0, '0);
    nsamp = $urandom_range(4, 60);
    flip  = $urandom_range(0, nsamp);
    base  = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 150) : $urandom_range(0, 4095);
    for (int k = 0; k < nsamp; k++) begin
      if (k == flip) base = $urandom_range(0, 4095);
      advance_clock(step_max);
      if ($urandom_range(0, 99) < 7)
        send_request(make_req(1'b1, clock_ms, ADC_W'($urandom_range(0, 4095)),
                              pick_command()), 1'b0, '0);
      r = $urandom_range(0, 99);
      if (r < 8) adc = $urandom_range(0, 4095);
      else if (r < 16) adc = $urandom_range(0, 150);
      else adc = base + int'($urandom_range(0, 64)) - 32;
      if (adc < 0) adc = 0;
      if (adc > 4095) adc = 4095;
      send_request(make_req(1'b0, clock_ms, ADC_W'(adc), CMD_W'($urandom_range(0, 255))),
                   1'b0, '0);
    end
    if ($urandom_range(0, 1)) begin
      advance_clock(step_max);
      send_request(make_req(1'b1, clock_ms, ADC_W'($urandom_range(0, 4095)), CMD_STOP),
                   1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 38);
  end

  always @(posedge clk) begin : status_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with nothing pending, phase", 32'(out_data.motor_phase), 0);
      end else begin
        want = pending_status.pop_front();
        check_field("motor_phase", 32'(out_data.motor_phase), 32'(want.motor_phase));
        check_field("drive_forward", 32'(out_data.drive_forward), 32'(want.drive_forward));
        check_field("drive_reverse", 32'(out_data.drive_reverse), 32'(want.drive_reverse));
        check_field("duty_compare", 32'(out_data.duty_compare), 32'(want.duty_compare));
        check_field("speed_step", 32'(out_data.speed_step), 32'(want.speed_step));
        check_field("mean_current_ma", 32'(out_data.mean_current_ma),
                    32'(want.mean_current_ma));
        check_field("trip_level_ma", 32'(out_data.trip_level_ma), 32'(want.trip_level_ma));
        check_field("over_count", 32'(out_data.over_count), 32'(want.over_count));
        check_field("event_code", 32'(out_data.event_code), 32'(want.event_code));
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    int step_max;
    // off, extremes of the sample field, ignored and saturated speed commands
    add_row(make_req(1'b0, 32'd0, 12'd0, 8'd0), 1'b1,
            '{PH_OFF, 1'b0, 1'b0, 10'd700, 3'd1, 12'd0, 13'd1000, 3'd0, EV_NONE});
    add_row(make_req(1'b0, 32'd1, 12'd4095, 8'd0), 1'b1,
            '{PH_OFF, 1'b0, 1'b0, 10'd700, 3'd1, 12'd547, 13'd1000, 3'd0, EV_NONE});
    add_row(make_req(1'b1, 32'd2, 12'd0, CMD_DOWN), 1'b1,
            '{PH_OFF, 1'b0, 1'b0, 10'd700, 3'd1, 12'd547, 13'd1000, 3'd0, EV_NONE});
    add_row(make_req(1'b1, 32'd3, 12'd0, 8'hFF), 1'b0, '0);
    add_row(make_req(1'b1, 32'd4, 12'd0, CMD_UP), 1'b0, '0);
    add_row(make_req(1'b1, 32'd5, 12'd0, CMD_UP), 1'b0, '0);
    add_row(make_req(1'b1, 32'd6, 12'd0, CMD_UP), 1'b0, '0);
    add_row(make_req(1'b1, 32'd7, 12'd0, CMD_UP), 1'b1,
            '{PH_OFF, 1'b0, 1'b0, 10'd999, 3'd4, 12'd547, 13'd1000, 3'd0, EV_NONE});
    add_row(make_req(1'b1, 32'd8, 12'd0, CMD_DOWN), 1'b0, '0);
    // forward run: start delay edge, calibration, then stall
    add_row(make_req(1'b1, 32'd100, 12'd0, CMD_FWD), 1'b0, '0);
    add_row(make_req(1'b0, 32'd2100, 12'd200, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd2101, 12'd200, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd3101, 12'd200, 8'd0), 1'b1,
            '{PH_RUN, 1'b1, 1'b0, 10'd900, 3'd3, 12'd591, 13'd738, 3'd0, EV_CALIB});
    add_row(make_req(1'b0, 32'd3200, 12'd4095, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd3300, 12'd4095, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd3400, 12'd4095, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd3500, 12'd4095, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd3600, 12'd4095, 8'd0), 1'b1,
            '{PH_STALL, 1'b0, 1'b0, 10'd900, 3'd3, 12'd2737, 13'd738, 3'd5, EV_STALL});
    // reverse restart out of the stall, then open load at exactly the timeout
    add_row(make_req(1'b1, 32'd4000, 12'd0, CMD_REV), 1'b0, '0);
    add_row(make_req(1'b0, 32'd6001, 12'd0, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd7002, 12'd0, 8'd0), 1'b1,
            '{PH_RUN, 1'b0, 1'b1, 10'd900, 3'd3, 12'd1642, 13'd2052, 3'd0, EV_CALIB});
    add_row(make_req(1'b0, 32'd7100, 12'd0, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd7200, 12'd0, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd7300, 12'd0, 8'd0), 1'b0, '0);
    add_row(make_req(1'b0, 32'd12300, 12'd0, 8'd0), 1'b1,
            '{PH_OPEN, 1'b0, 1'b0, 10'd900, 3'd3, 12'd0, 13'd2052, 3'd0, EV_OPEN});
    add_row(make_req(1'b1, 32'd12400, 12'd0, CMD_STOP), 1'b1,
            '{PH_OFF, 1'b0, 1'b0, 10'd900, 3'd3, 12'd0, 13'd1000, 3'd0, EV_NONE});
    // long gap: still only one transition on the tick
    add_row(make_req(1'b1, 32'd20000, 12'd0, CMD_FWD), 1'b0, '0);
    add_row(make_req(1'b0, 32'd40001, 12'd2048, 8'd0), 1'b0, '0);

    guard_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].fixed_want,
                                       dir_rows[i].want);

    clock_ms = $urandom;
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      quiet    = (ph == 4);
      step_max = $urandom_range(20, 600);
      case (ph)
        0: ;
        1: begin
          foreach (reg_plan[i]) reg_plan[i] = '0;
          step_max = 40;
        end
        2: begin
          foreach (reg_plan[i]) reg_plan[i] = 16'hFFFF;
          step_max = 3000;
        end
        9: begin
          reg_plan[REG_START_DELAY] = 16'd2000;
          reg_plan[REG_CALIB_END]   = 16'd3000;
          reg_plan[REG_RUN_LIMIT]   = 16'd20000;
          reg_plan[REG_OPEN_TMO]    = 16'd5000;
          reg_plan[REG_STALL_LIMIT] = 16'd5;
          reg_plan[REG_OPEN_LEVEL]  = 16'd40;
          reg_plan[REG_MIN_CALIB]   = 16'd50;
          reg_plan[REG_IDLE_THR]    = 16'd1000;
          step_max = 400;
        end
        default: begin
          reg_plan[REG_START_DELAY] = 16'($urandom_range(0, 3000));
          reg_plan[REG_CALIB_END]   = 16'($urandom_range(0, 5000));
          reg_plan[REG_RUN_LIMIT]   = 16'($urandom_range(0, 30000));
          reg_plan[REG_OPEN_TMO]    = 16'($urandom_range(0, 8000));
          reg_plan[REG_STALL_LIMIT] = 16'($urandom_range(0, 7));
          reg_plan[REG_OPEN_LEVEL]  = 16'($urandom_range(0, 400));
          reg_plan[REG_MIN_CALIB]   = 16'($urandom_range(0, 800));
          reg_plan[REG_IDLE_THR]    = 16'($urandom_range(0, 4095));
        end
      endcase
      if (ph != 0) load_registers();
      phase_end = accepted_count + 100;
      while (accepted_count < phase_end) motor_run(step_max);
    end
    quiet = 1'b0;
    settle();
    repeat (12) @(posedge clk);

    if (status_mismatches == 0)
      $display("motor_current_guard_fsm_tb OK");
    else
      $display("motor_current_guard_fsm_tb NOT OK");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("motor_current_guard_fsm_tb NOT OK");
    $finish;
  end

endmodule
